[src/smm_pkg.sv]
// shared types and constants for the smallest missing multiple unit
`default_nettype none
package smm_pkg;

  localparam int VAL_W = 16;
  localparam int RES_W = 27;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             last;
  } in_t;

  typedef struct packed {
    logic [RES_W-1:0] smallest_missing;
    logic             beyond_map;
  } out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_MUL
  } state_t;

endpackage
`default_nettype wire

[src/smm_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none
module smm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read and write at one address return the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[src/smm_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none
module smm_div (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [smm_pkg::VAL_W-1:0] dividend,
  input  wire logic [smm_pkg::VAL_W-1:0] divisor,
  output logic                         busy,
  output logic [smm_pkg::VAL_W-1:0]    quotient,
  output logic [smm_pkg::VAL_W-1:0]    remainder
);

  localparam int W  = smm_pkg::VAL_W;
  localparam int CW = $clog2(W);

  logic [CW-1:0] cnt;
  logic [W-1:0]  dvd;
  logic [W-1:0]  rem;
  logic [W-1:0]  dsr;
  logic [W:0]    shifted;
  logic [W+1:0]  diff;
  logic          ge;

  assign shifted = {rem, dvd[W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr};
  assign ge      = ~diff[W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      dvd  <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[W-1:0] : shifted[W-1:0];
      dvd <= {dvd[W-2:0], ge};
      cnt <= cnt + 1'b1;
      if (cnt == CW'(W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quotient  = dvd;
  assign remainder = rem;

endmodule
`default_nettype wire

[src/smm_mul.sv]
// bit-serial shift-add multiplier, product kept to the result width
`default_nettype none
module smm_mul #(
  parameter int M_W = 11
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [smm_pkg::VAL_W-1:0] mcand_in,
  input  wire logic [M_W-1:0]            mplier_in,
  output logic                           busy,
  output logic [smm_pkg::RES_W-1:0]      product
);

  localparam int RW = smm_pkg::RES_W;
  localparam int CW = $clog2(M_W);

  logic [CW-1:0]  cnt;
  logic [RW-1:0]  mcand;
  logic [M_W-1:0] mplier;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy    <= 1'b1;
      cnt     <= '0;
      product <= '0;
      mcand   <= RW'(mcand_in);
      mplier  <= mplier_in;
    end else if (busy) begin
      if (mplier[0]) begin
        product <= product + mcand;
      end
      mcand  <= {mcand[RW-2:0], 1'b0};
      mplier <= {1'b0, mplier[M_W-1:1]};
      cnt    <= cnt + 1'b1;
      if (cnt == CW'(M_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[src/smallest_missing_multiple_unit.sv]
// top level: smallest missing positive multiple of a configured base
//
//  channel | direction | payload      | handshake
//  --------+-----------+--------------+-------------------------------
//  in      | input     | in_data      | in_valid / in_stall
//  out     | output    | out_data     | out_valid / out_stall
//  cfg     | input     | cfg_wdata    | cfg_we, write only
//
// a value is accepted, passes one divider step per quotient bit, then marks the map.
// a last value adds the ram scan (read and clear one bit a cycle, then drain
// the last read), the serial multiplier over the clog2(MAP_BITS+2)-bit index
// and the result load.
// after reset a clearing pass over all MAP_BITS map bits runs with in_stall high.
// the result sits in an output register; a stalled beat only blocks the next
// result, not the values of the following set.
`default_nettype none
module smallest_missing_multiple_unit #(
  parameter int MAP_BITS = 1024
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire smm_pkg::in_t              in_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output smm_pkg::out_t                  out_data,
  input  wire logic                      cfg_we,
  input  wire logic [smm_pkg::VAL_W-1:0] cfg_wdata
);

  localparam int W      = smm_pkg::VAL_W;
  localparam int ADDR_W = $clog2(MAP_BITS);
  localparam int CNT_W  = $clog2(MAP_BITS + 1);
  localparam int IDX_W  = $clog2(MAP_BITS + 2);

  smm_pkg::state_t state, state_next;

  logic [W-1:0]      mult_base;
  logic [W-1:0]      base_eff;
  logic              cur_last;
  logic [CNT_W-1:0]  scan_cnt;
  logic              rd_pend;
  logic [ADDR_W-1:0] rd_idx;
  logic              found;
  logic [ADDR_W-1:0] miss_idx;

  logic              div_start, div_busy;
  logic [W-1:0]      div_q, div_r;
  logic              mul_start, mul_busy;
  logic [smm_pkg::RES_W-1:0] mul_p;
  logic [IDX_W-1:0]  mult_idx;

  logic              ram_we, ram_wdata, ram_rdata;
  logic [ADDR_W-1:0] ram_waddr;
  logic              mark_ok, issuing, scan_done, out_load;

  assign base_eff = (mult_base == '0) ? W'(1) : mult_base;

  // only an exact division with a nonzero quotient within the map marks a bit
  assign mark_ok = (div_r == '0) && (div_q != '0) &&
                   ({16'd0, div_q} <= 32'(MAP_BITS));

  assign issuing   = (state == smm_pkg::ST_SCAN) && (scan_cnt != CNT_W'(MAP_BITS));
  assign scan_done = (scan_cnt == CNT_W'(MAP_BITS)) && !rd_pend;
  assign mult_idx  = found ? (IDX_W'(miss_idx) + 1'b1) : IDX_W'(MAP_BITS + 1);

  always_comb begin
    state_next = state;
    case (state)
      smm_pkg::ST_CLEAR: begin
        if (scan_cnt == CNT_W'(MAP_BITS - 1)) state_next = smm_pkg::ST_IDLE;
      end
      smm_pkg::ST_IDLE: begin
        if (in_valid) state_next = smm_pkg::ST_DIV;
      end
      smm_pkg::ST_DIV: begin
        if (!div_busy) state_next = cur_last ? smm_pkg::ST_SCAN : smm_pkg::ST_IDLE;
      end
      smm_pkg::ST_SCAN: begin
        if (scan_done) state_next = smm_pkg::ST_MUL;
      end
      smm_pkg::ST_MUL: begin
        if (!mul_busy && (!out_valid || !out_stall)) state_next = smm_pkg::ST_IDLE;
      end
      default: state_next = smm_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    in_stall  = (state != smm_pkg::ST_IDLE);
    div_start = (state == smm_pkg::ST_IDLE) && in_valid;
    mul_start = (state == smm_pkg::ST_SCAN) && scan_done;
    out_load  = (state == smm_pkg::ST_MUL) && !mul_busy && (!out_valid || !out_stall);
    ram_we    = 1'b0;
    ram_waddr = scan_cnt[ADDR_W-1:0];
    ram_wdata = 1'b0;
    case (state)
      smm_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
      end
      smm_pkg::ST_DIV: begin
        if (!div_busy && mark_ok) begin
          ram_we    = 1'b1;
          ram_waddr = ADDR_W'(div_q - 1'b1);
          ram_wdata = 1'b1;
        end
      end
      smm_pkg::ST_SCAN: begin
        // clear each bit as it is read so the map is empty for the next set
        ram_we = issuing;
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= smm_pkg::ST_CLEAR;
      mult_base <= W'(1);
      scan_cnt  <= '0;
      rd_pend   <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) mult_base <= cfg_wdata;
      if (div_start) cur_last <= in_data.last;

      if (state == smm_pkg::ST_DIV && !div_busy && cur_last) begin
        scan_cnt <= '0;
        found    <= 1'b0;
      end else if (state == smm_pkg::ST_CLEAR || issuing) begin
        scan_cnt <= scan_cnt + 1'b1;
      end

      rd_pend <= issuing;
      rd_idx  <= scan_cnt[ADDR_W-1:0];
      if (rd_pend && !ram_rdata && !found) begin
        found    <= 1'b1;
        miss_idx <= rd_idx;
      end

      if (out_load) begin
        out_valid                 <= 1'b1;
        out_data.smallest_missing <= mul_p;
        out_data.beyond_map       <= !found;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  smm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (in_data.value),
    .divisor   (base_eff),
    .busy      (div_busy),
    .quotient  (div_q),
    .remainder (div_r)
  );

  smm_ram #(
    .WIDTH (1),
    .DEPTH (MAP_BITS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_cnt[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  smm_mul #(
    .M_W (IDX_W)
  ) u_mul (
    .clk       (clk),
    .rst       (rst),
    .start     (mul_start),
    .mcand_in  (base_eff),
    .mplier_in (mult_idx),
    .busy      (mul_busy),
    .product   (mul_p)
  );

endmodule
`default_nettype wire

[src/smm_checker.sv]
// port-level checks for the smallest missing multiple unit, bound to the top
`default_nettype none
module smm_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_valid,
  input wire logic                      in_stall,
  input wire logic                      out_valid,
  input wire logic                      out_stall,
  input wire smm_pkg::out_t             out_data
);

  // reset starts the map clearing pass with no result pending
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (in_stall && !out_valid))
    else $error("block not clearing after reset");

  // an accepted value keeps the block busy while it divides
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while divider busy");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result beat changed");

endmodule

bind smallest_missing_multiple_unit smm_checker u_chk (.*);
`default_nettype wire

[dv/smallest_missing_multiple_unit_test.sv]
// self-checking testbench for smallest_missing_multiple_unit: directed table, then random sets
module smallest_missing_multiple_unit_test;

  localparam int MAP_N         = 1024;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 6000;
  localparam int LIMIT         = 1000000;
  localparam int ITEM_TARGET   = 950;
  localparam int HOLD_PHASE    = 1;
  localparam int FULL_PHASE    = 3;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                 kind;
    logic [smm_pkg::VAL_W-1:0] value;   // base for a config row
    logic                      last;
    logic                      typed;   // expected result given in the row
    smm_pkg::out_t             res;
  } row_t;

  localparam int DIR_ROWS = 25;
  localparam row_t DIRECTED [0:DIR_ROWS-1] = '{
    // base 1 from reset: zero value, duplicates, indices past the map
    '{ROW_BEAT, 16'd0,     1'b1, 1'b1, '{27'd1, 1'b0}},
    '{ROW_BEAT, 16'd2,     1'b0, 1'b0, '0},
    '{ROW_BEAT, 16'd1,     1'b0, 1'b0, '0},
    '{ROW_BEAT, 16'd1,     1'b0, 1'b0, '0},
    '{ROW_BEAT, 16'd3,     1'b1, 1'b1, '{27'd4, 1'b0}},
    '{ROW_BEAT, 16'd65535, 1'b1, 1'b1, '{27'd1, 1'b0}},
    '{ROW_BEAT, 16'd1025,  1'b0, 1'b0, '0},
    '{ROW_BEAT, 16'd1024,  1'b1, 1'b1, '{27'd1, 1'b0}},
    // widest base
    '{ROW_CFG,  16'd65535, 1'b0, 1'b0, '0},
    '{ROW_BEAT, 16'd65535, 1'b1, 1'b1, '{27'd131070, 1'b0}},
    '{ROW_BEAT, 16'd65534, 1'b1, 1'b1, '{27'd65535, 1'b0}},
    // base of zero behaves as one
    '{ROW_CFG,  16'd0,     1'b0, 1'b0, '0},
    '{ROW_BEAT, 16'd1,     1'b1, 1'b1, '{27'd2, 1'b0}},
    '{ROW_CFG,  16'd7,     1'b0, 1'b0, '0},
    '{ROW_BEAT, 16'd14,    1'b0, 1'b0, '0},
    '{ROW_BEAT, 16'd7,     1'b0, 1'b0, '0},
    '{ROW_BEAT, 16'd21,    1'b1, 1'b1, '{27'd28, 1'b0}},
    '{ROW_BEAT, 16'd8,     1'b1, 1'b1, '{27'd7, 1'b0}},
    // top index marked, one past it ignored
    '{ROW_CFG,  16'd3,     1'b0, 1'b0, '0},
    '{ROW_BEAT, 16'd3,     1'b0, 1'b0, '0},
    '{ROW_BEAT, 16'd3072,  1'b0, 1'b0, '0},
    '{ROW_BEAT, 16'd3075,  1'b0, 1'b0, '0},
    '{ROW_BEAT, 16'd9,     1'b0, 1'b0, '0},
    '{ROW_BEAT, 16'd6,     1'b0, 1'b0, '0},
    '{ROW_BEAT, 16'd12,    1'b1, 1'b0, '0}
  };

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  smm_pkg::in_t              in_data = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  smm_pkg::out_t             out_data;
  logic                      cfg_we = 1'b0;
  logic [smm_pkg::VAL_W-1:0] cfg_wdata = '0;

  // predictor state
  bit                        present [1:MAP_N];
  logic [smm_pkg::VAL_W-1:0] base_k = 16'd1;
  smm_pkg::out_t             missing_q [$];

  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int errors = 0;
  int values_sent = 0;
  int sets_closed = 0;
  int results_seen = 0;
  int saturated_seen = 0;
  int bases_used = 0;
  int cycle_count = 0;
  int order [MAP_N];

  smallest_missing_multiple_unit #(
    .MAP_BITS(MAP_N)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("%0t: timeout with %0d results still expected", $time, missing_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic queue_expected(input smm_pkg::out_t res);
    missing_q = {missing_q, res};
  endtask

  // marks one value and, on the last of a set, resolves the missing multiple
  task automatic predict_beat(input smm_pkg::in_t beat, output bit emits,
                              output smm_pkg::out_t res);
    int unsigned k;
    int unsigned idx;
    int unsigned m;
    k = (base_k == 0) ? 1 : base_k;
    emits = 1'b0;
    res = '0;
    if (beat.value != 0 && beat.value % k == 0) begin
      idx = beat.value / k;
      if (idx <= MAP_N) present[idx] = 1'b1;
    end
    if (beat.last) begin
      m = MAP_N + 1;
      for (int i = MAP_N; i >= 1; i--) begin
        if (!present[i]) m = i;
      end
      res.smallest_missing = smm_pkg::RES_W'(k * m);
      res.beyond_map = (m == MAP_N + 1);
      for (int i = 1; i <= MAP_N; i++) present[i] = 1'b0;
      emits = 1'b1;
    end
  endtask

  task automatic offer(input logic [smm_pkg::VAL_W-1:0] v, input logic lst,
                       input logic typed, input smm_pkg::out_t typed_res);
    smm_pkg::in_t  beat;
    bit            emits;
    smm_pkg::out_t want;
    beat.value = v;
    beat.last = lst;
    while (!calm && $urandom_range(0, 99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_beat(beat, emits, want);
    if (emits) queue_expected(typed ? typed_res : want);
    values_sent++;
    if (lst) sets_closed++;
  endtask

  // base changes only once the block has drained
  task automatic write_base(input logic [smm_pkg::VAL_W-1:0] k);
    in_valid <= 1'b0;
    while (missing_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= k;
    @(posedge clk);
    cfg_we <= 1'b0;
    base_k = k;
    bases_used++;
  endtask

  // mostly multiples around a dense prefix, with zeros, strays and past-map values
  task automatic send_set(input int len);
    int unsigned k;
    int unsigned span;
    int unsigned pick;
    int unsigned prod;
    logic [smm_pkg::VAL_W-1:0] v;
    k = (base_k == 0) ? 1 : base_k;
    span = $urandom_range(1, len + 2);
    for (int j = 0; j < len; j++) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) prod = k * $urandom_range(1, span);
      else if (pick < 80) prod = 0;
      else if (pick < 92) prod = $urandom_range(0, 16'hFFFF);
      else prod = k * $urandom_range(MAP_N + 1, MAP_N + 64);
      v = (prod > 16'hFFFF) ? smm_pkg::VAL_W'($urandom) : smm_pkg::VAL_W'(prod);
      offer(v, j == len - 1, 1'b0, '0);
    end
  endtask

  // every index once in shuffled order, so the answer saturates
  task automatic send_full_map();
    int unsigned k;
    int j;
    int t;
    k = (base_k == 0) ? 1 : base_k;
    for (int i = 0; i < MAP_N; i++) order[i] = i + 1;
    for (int i = MAP_N - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < MAP_N; i++) begin
      offer(smm_pkg::VAL_W'(k * order[i]), i == MAP_N - 1, 1'b0, '0);
    end
  endtask

  task automatic check_result(input smm_pkg::out_t got);
    smm_pkg::out_t want;
    if (missing_q.size() == 0) begin
      $display("%0t: unexpected result: expected none, got %0d/%0b", $time,
               got.smallest_missing, got.beyond_map);
      errors++;
    end else begin
      want = missing_q.pop_front();
      if (got.smallest_missing !== want.smallest_missing) begin
        $display("%0t: smallest_missing mismatch: expected %0d, got %0d", $time,
                 want.smallest_missing, got.smallest_missing);
        errors++;
      end
      if (got.beyond_map !== want.beyond_map) begin
        $display("%0t: beyond_map mismatch: expected %0b, got %0b", $time,
                 want.beyond_map, got.beyond_map);
        errors++;
      end
      if (got.beyond_map === 1'b1 && want.beyond_map) saturated_seen++;
    end
    results_seen++;
  endtask

  // receiver: random stalls, one long hold-off to back up the input side
  initial begin
    int  hold_left;
    bit  held_once;
    hold_left = 0;
    held_once = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && !out_stall) check_result(out_data);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!held_once && hold_req) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 35);
      end
    end
  end

  initial begin
    int phase;
    int nsets;
    logic [smm_pkg::VAL_W-1:0] k;
    for (int i = 1; i <= MAP_N; i++) present[i] = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int n = 0; n < DIR_ROWS; n++) begin
      if (DIRECTED[n].kind == ROW_CFG) write_base(DIRECTED[n].value);
      else offer(DIRECTED[n].value, DIRECTED[n].last, DIRECTED[n].typed, DIRECTED[n].res);
    end

    phase = 0;
    while (values_sent < ITEM_TARGET) begin
      // the saturating phase runs with no idling on either side
      calm = (phase == FULL_PHASE);
      case (phase)
        0: k = 16'hFFFF;
        1: k = 16'd0;
        FULL_PHASE: k = smm_pkg::VAL_W'($urandom_range(1, 63));
        default: begin
          case ($urandom_range(0, 7))
            0: k = 16'd0;
            1: k = 16'd1;
            2: k = 16'hFFFF;
            3: k = smm_pkg::VAL_W'($urandom_range(2, 16'hFFFE));
            default: k = smm_pkg::VAL_W'($urandom_range(1, 63));
          endcase
        end
      endcase
      write_base(k);
      if (phase == FULL_PHASE) send_full_map();
      nsets = $urandom_range(2, 5);
      if (phase == HOLD_PHASE) begin
        // receiver holds off while these sets keep coming
        nsets = 5;
        hold_req = 1'b1;
      end
      for (int s = 0; s < nsets; s++) begin
        send_set(($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16));
      end
      phase++;
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (missing_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d values in %0d sets across %0d base settings, checked %0d results",
             values_sent, sets_closed, bases_used, results_seen);
    $display("saturated answers seen: %0d, output hold-off of %0d cycles applied",
             saturated_seen, HOLD_CYCLES);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
